// File: rtl/core/wpdc_pkg.sv
// Shared types, register codes and field widths for the word packet deframer/checker.
package wpdc_pkg;

    localparam int WORD_W           = 32;
    localparam int INDEX_W          = 8;
    localparam int FLAGS_W          = 6;
    localparam int CFG_INDEX_W      = 3;
    localparam int CFG_DATA_W       = 64;
    localparam int TYPE_CODES       = 5;
    localparam int PKT_LEN_DEF      = 140;

    // Result packing: index, word, event, kind, origin, unit, flags, zero pad
    localparam int RES_BITS   = INDEX_W + 5 * WORD_W + FLAGS_W;
    localparam int M_TDATA_W  = ((RES_BITS + 7) / 8) * 8;

    // Error flag bit positions
    localparam int FLAG_SIZE      = 0;
    localparam int FLAG_DATE      = 1;
    localparam int FLAG_TYPE      = 2;
    localparam int FLAG_CHECKSUM  = 3;
    localparam int FLAG_FOOTER    = 4;
    localparam int FLAG_MISPLACED = 5;

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_HEADER      = 3'd0,
        REG_FOOTER      = 3'd1,
        REG_SIZE        = 3'd2,
        REG_DATE        = 3'd3,
        REG_TYPE_PAIR_A = 3'd4,
        REG_TYPE_PAIR_B = 3'd5,
        REG_TYPE_FIFTH  = 3'd6
    } cfg_reg_t;

    typedef struct packed {
        logic [WORD_W-1:0] header_code;
        logic [WORD_W-1:0] footer_code;
        logic [WORD_W-1:0] size_code;
        logic [WORD_W-1:0] date_code;
        logic [TYPE_CODES-1:0][WORD_W-1:0] type_codes;
    } cfg_t;

    typedef struct packed {
        logic               is_status;
        logic [INDEX_W-1:0] payload_index;
        logic [WORD_W-1:0]  payload_word;
        logic [WORD_W-1:0]  evt_num;
        logic [WORD_W-1:0]  packet_kind;
        logic [WORD_W-1:0]  origin_word;
        logic [WORD_W-1:0]  unit_id;
        logic [FLAGS_W-1:0] error_flags;
    } result_t;

    typedef enum logic [1:0] {
        ST_HUNT  = 2'b01,
        ST_FRAME = 2'b10
    } frame_state_t;

endpackage

// File: rtl/core/wpdc_cfg.sv
// Configuration register file: header, footer, size, date and type codes.
module wpdc_cfg (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [wpdc_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  logic [wpdc_pkg::CFG_DATA_W-1:0]     cfg_data,
    output wpdc_pkg::cfg_t                      cfg
);
    import wpdc_pkg::*;

    cfg_t cfg_reg, cfg_next;

    assign cfg_ready = 1'b1;
    assign cfg       = cfg_reg;

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_valid) begin
            unique case (cfg_index)
                REG_HEADER:      cfg_next.header_code   = cfg_data[WORD_W-1:0];
                REG_FOOTER:      cfg_next.footer_code   = cfg_data[WORD_W-1:0];
                REG_SIZE:        cfg_next.size_code     = cfg_data[WORD_W-1:0];
                REG_DATE:        cfg_next.date_code     = cfg_data[WORD_W-1:0];
                REG_TYPE_PAIR_A: begin
                    cfg_next.type_codes[0] = cfg_data[WORD_W-1:0];
                    cfg_next.type_codes[1] = cfg_data[2*WORD_W-1:WORD_W];
                end
                REG_TYPE_PAIR_B: begin
                    cfg_next.type_codes[2] = cfg_data[WORD_W-1:0];
                    cfg_next.type_codes[3] = cfg_data[2*WORD_W-1:WORD_W];
                end
                REG_TYPE_FIFTH:  cfg_next.type_codes[4] = cfg_data[WORD_W-1:0];
                default:         cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg <= '0;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

// File: rtl/core/wpdc_frame.sv
// Input register, packet framing state, checksum and field checks.
module wpdc_frame #(
    parameter int PKT_LEN = wpdc_pkg::PKT_LEN_DEF
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  wpdc_pkg::cfg_t                 cfg,
    input  logic                           s_valid,
    output logic                           s_ready,
    input  logic [wpdc_pkg::WORD_W-1:0]    s_word,
    input  logic                           res_ready,
    output logic                           res_valid,
    output wpdc_pkg::result_t              res
);
    import wpdc_pkg::*;

    localparam int POS_W = $clog2(PKT_LEN);
    localparam logic [POS_W-1:0] POS_SIZE     = POS_W'(1);
    localparam logic [POS_W-1:0] POS_DATE     = POS_W'(2);
    localparam logic [POS_W-1:0] POS_TYPE     = POS_W'(3);
    localparam logic [POS_W-1:0] POS_EVENT    = POS_W'(4);
    localparam logic [POS_W-1:0] POS_ORIGIN   = POS_W'(5);
    localparam logic [POS_W-1:0] POS_PAYLOAD  = POS_W'(6);
    localparam logic [POS_W-1:0] POS_LAST_PL  = POS_W'(PKT_LEN - 4);
    localparam logic [POS_W-1:0] POS_UNIT     = POS_W'(PKT_LEN - 3);
    localparam logic [POS_W-1:0] POS_CHECKSUM = POS_W'(PKT_LEN - 2);

    logic              in_vld_reg, in_vld_next;
    logic [WORD_W-1:0] in_word_reg;

    frame_state_t      state_reg, state_next;
    logic [POS_W-1:0]  pos_reg, pos_next;
    logic [WORD_W-1:0] sum_reg, sum_next;
    logic              misplaced_reg, misplaced_next;
    logic [2:0]        ferr_reg, ferr_next;
    logic [WORD_W-1:0] event_reg, event_next;
    logic [WORD_W-1:0] kind_reg, kind_next;
    logic [WORD_W-1:0] origin_reg, origin_next;
    logic [WORD_W-1:0] unit_reg, unit_next;
    logic [WORD_W-1:0] csum_reg, csum_next;

    logic              step;
    logic              is_hdr;
    logic              type_ok;
    logic [POS_W-1:0]  pl_index;
    logic [WORD_W-1:0] w;

    assign w       = in_word_reg;
    assign step    = in_vld_reg && res_ready;
    assign s_ready = !in_vld_reg || res_ready;
    assign is_hdr  = (w == cfg.header_code);
    assign pl_index = pos_reg - POS_PAYLOAD;

    always_comb begin
        type_ok = 1'b0;
        for (int i = 0; i < TYPE_CODES; i++) begin
            if (w == cfg.type_codes[i]) type_ok = 1'b1;
        end
    end

    always_comb begin
        in_vld_next = in_vld_reg;
        if (s_valid && s_ready) begin
            in_vld_next = 1'b1;
        end else if (step) begin
            in_vld_next = 1'b0;
        end
    end

    always_comb begin
        state_next     = state_reg;
        pos_next       = pos_reg;
        sum_next       = sum_reg;
        misplaced_next = misplaced_reg;
        ferr_next      = ferr_reg;
        event_next     = event_reg;
        kind_next      = kind_reg;
        origin_next    = origin_reg;
        unit_next      = unit_reg;
        csum_next      = csum_reg;
        res_valid      = 1'b0;
        res            = '0;

        if (step) begin
            unique case (state_reg)
                ST_HUNT: begin
                    if (is_hdr) begin
                        misplaced_next = 1'b0;
                        state_next     = ST_FRAME;
                        pos_next       = POS_SIZE;
                        sum_next       = w;
                        ferr_next      = '0;
                    end
                end
                ST_FRAME: begin
                    if (is_hdr) begin
                        // header inside a packet: restart framing here
                        misplaced_next = 1'b1;
                        pos_next       = POS_SIZE;
                        sum_next       = w;
                        ferr_next      = '0;
                    end else begin
                        if (pos_reg != POS_CHECKSUM) sum_next = sum_reg + w;
                        pos_next = pos_reg + POS_W'(1);
                        priority if (pos_reg == POS_SIZE) begin
                            if (w != cfg.size_code) ferr_next[FLAG_SIZE] = 1'b1;
                        end else if (pos_reg == POS_DATE) begin
                            if (w != cfg.date_code) ferr_next[FLAG_DATE] = 1'b1;
                        end else if (pos_reg == POS_TYPE) begin
                            kind_next = w;
                            if (!type_ok) ferr_next[FLAG_TYPE] = 1'b1;
                        end else if (pos_reg == POS_EVENT) begin
                            event_next = w;
                        end else if (pos_reg == POS_ORIGIN) begin
                            origin_next = w;
                        end else if (pos_reg <= POS_LAST_PL) begin
                            res_valid         = 1'b1;
                            res.payload_index = INDEX_W'(pl_index);
                            res.payload_word  = w;
                        end else if (pos_reg == POS_UNIT) begin
                            unit_next = w;
                        end else if (pos_reg == POS_CHECKSUM) begin
                            csum_next = w;
                        end else begin
                            // footer: sum already includes this word
                            res_valid        = 1'b1;
                            res.is_status    = 1'b1;
                            res.evt_num      = event_reg;
                            res.packet_kind  = kind_reg;
                            res.origin_word  = origin_reg;
                            res.unit_id      = unit_reg;
                            res.error_flags[FLAG_SIZE]      = ferr_reg[FLAG_SIZE];
                            res.error_flags[FLAG_DATE]      = ferr_reg[FLAG_DATE];
                            res.error_flags[FLAG_TYPE]      = ferr_reg[FLAG_TYPE];
                            res.error_flags[FLAG_CHECKSUM]  = (csum_reg != sum_next);
                            res.error_flags[FLAG_FOOTER]    = (w != cfg.footer_code);
                            res.error_flags[FLAG_MISPLACED] = misplaced_reg;
                            state_next = ST_HUNT;
                            pos_next   = '0;
                        end
                    end
                end
                default: state_next = ST_HUNT;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_vld_reg    <= 1'b0;
            state_reg     <= ST_HUNT;
            pos_reg       <= '0;
            sum_reg       <= '0;
            misplaced_reg <= 1'b0;
            ferr_reg      <= '0;
        end else begin
            in_vld_reg    <= in_vld_next;
            state_reg     <= state_next;
            pos_reg       <= pos_next;
            sum_reg       <= sum_next;
            misplaced_reg <= misplaced_next;
            ferr_reg      <= ferr_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) in_word_reg <= s_word;
        event_reg  <= event_next;
        kind_reg   <= kind_next;
        origin_reg <= origin_next;
        unit_reg   <= unit_next;
        csum_reg   <= csum_next;
    end

endmodule

// File: rtl/core/wpdc_out.sv
// Result register: holds one request for the master side until it is taken.
module wpdc_out (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              res_valid,
    output logic                              res_ready,
    input  wpdc_pkg::result_t                 res,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [wpdc_pkg::M_TDATA_W-1:0]    m_tdata,
    output logic                              m_tuser
);
    import wpdc_pkg::*;

    logic    vld_reg, vld_next;
    result_t res_reg;

    assign res_ready = !vld_reg || m_tready;
    assign vld_next  = res_valid ? 1'b1 : (vld_reg && !m_tready);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= 1'b0;
        end else begin
            vld_reg <= vld_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (res_valid) res_reg <= res;
    end

    assign m_tvalid = vld_reg;
    assign m_tuser  = res_reg.is_status;
    assign m_tdata  = {{(M_TDATA_W - RES_BITS){1'b0}},
                       res_reg.error_flags,
                       res_reg.unit_id,
                       res_reg.origin_word,
                       res_reg.packet_kind,
                       res_reg.evt_num,
                       res_reg.payload_word,
                       res_reg.payload_index};

endmodule

// File: rtl/core/word_packet_deframer_checker.sv
// Top level of the word packet deframer and additive checksum checker.
//
// Slave stream (s_*): one 32-bit link word per request. The block drops words
// until one equals the header code, then frames a fixed packet of
// PKT_LEN words: header, size, date, type, event number, origin,
// payload, unit id, checksum, footer. A header seen mid-packet restarts
// framing and marks the packet as misplaced.
// Master stream (m_*): tuser=0 carries a payload word with its index;
// tuser=1 carries the end-of-packet status with captured fields and flags.
// Config channel (cfg_*): index/data writes, always ready; write while idle.
// A word is registered on input and its result is registered on output.
// Throughput: one word per cycle while the output register is free or m_tready
// is high, set by the single compare-and-add step on the registered word.
// Reset clears the framer back to hunting, empties both stages and zeroes
// the config registers. When m_tready is low the result holds, the input
// register fills, and s_tready drops until the master side takes the result.
module word_packet_deframer_checker #(
    parameter int PKT_LEN = wpdc_pkg::PKT_LEN_DEF
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [wpdc_pkg::WORD_W-1:0]       s_tdata,   // [31:0] stream_word
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // [7:0] payload_index, [39:8] payload_word, [71:40] evt_num,
    // [103:72] packet_kind, [135:104] origin_word, [167:136] unit_id,
    // [173:168] error_flags, [175:174] zero
    output logic [wpdc_pkg::M_TDATA_W-1:0]    m_tdata,
    output logic                              m_tuser,   // [0] is_status
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [wpdc_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  logic [wpdc_pkg::CFG_DATA_W-1:0]   cfg_data
);
    import wpdc_pkg::*;

    cfg_t    cfg;
    logic    res_valid;
    logic    res_ready;
    result_t res;

    wpdc_cfg u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    wpdc_frame #(
        .PKT_LEN (PKT_LEN)
    ) u_frame (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg       (cfg),
        .s_valid   (s_tvalid),
        .s_ready   (s_tready),
        .s_word    (s_tdata),
        .res_ready (res_ready),
        .res_valid (res_valid),
        .res       (res)
    );

    wpdc_out u_out (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res       (res),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

endmodule

// File: sim/tb.sv
// Self-checking testbench for word_packet_deframer_checker: probe table, then random packets.
module tb;
    import wpdc_pkg::*;

    localparam int PKT    = PKT_LEN_DEF;
    localparam int PROBES = 24;

    // first register setting, also used by the probe table
    localparam logic [31:0] HDR_A   = 32'hA5C3_0F1E;
    localparam logic [31:0] FTR_A   = 32'h7E57_F007;
    localparam logic [31:0] SIZE_A  = 32'd140;
    localparam logic [31:0] DATE_A  = 32'h5EED_0D47;
    localparam logic [63:0] KINDS_A = 64'h0000_0202_0000_0101;
    localparam logic [63:0] KINDS_B = 64'h0000_0404_0000_0303;
    localparam logic [31:0] KIND5_A = 32'h0000_0505;

    logic                  aclk      = 1'b0;
    logic                  aresetn   = 1'b0;
    logic                  s_tvalid  = 1'b0;
    logic                  s_tready;
    logic [WORD_W-1:0]     s_tdata   = '0;
    logic                  m_tvalid;
    logic                  m_tready  = 1'b0;
    logic [M_TDATA_W-1:0]  m_tdata;
    logic                  m_tuser;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    cfg_reg_t              cfg_index = REG_HEADER;
    logic [CFG_DATA_W-1:0] cfg_data  = '0;

    word_packet_deframer_checker #(.PKT_LEN(PKT)) dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    always #5 aclk = ~aclk;

    // register copies
    logic [31:0] hdr_code  = '0;
    logic [31:0] ftr_code  = '0;
    logic [31:0] size_code = '0;
    logic [31:0] date_code = '0;
    logic [31:0] kind_codes [TYPE_CODES] = '{default: '0};

    // framer state
    bit          in_hunt   = 1'b1;
    int unsigned pos       = 0;
    logic [31:0] run_sum   = '0;
    bit          misplaced = 1'b0;
    logic [2:0]  field_err = '0;
    logic [31:0] held_event = '0, held_kind = '0, held_origin = '0;
    logic [31:0] held_unit  = '0, held_sum  = '0;

    result_t deframed_q [$];

    int  mismatches = 0;
    int  n_words = 0, n_packets = 0, n_settings = 0;
    int  n_payload = 0, n_status = 0;
    bit  calm = 1'b0;
    bit  held_off = 1'b0;

    logic [31:0] probe_word  [PROBES];
    int          probe_index [PROBES];

    task automatic note_mismatch(input string field, input logic [31:0] got,
                                 input logic [31:0] want);
        mismatches++;
        $display("tb: mismatch on %s: got %h, want %h", field, got, want);
    endtask

    // one stream word through the framer; got is set when it yields a result
    task automatic frame_word(input logic [31:0] w, output bit got, output result_t r);
        int unsigned p;
        bit          kind_ok;
        got = 1'b0;
        r   = '0;
        if (w == hdr_code) begin
            // a header while framing restarts the packet and marks it
            misplaced = !in_hunt;
            in_hunt   = 1'b0;
            pos       = 1;
            run_sum   = w;
            field_err = '0;
        end else if (!in_hunt) begin
            p   = pos;
            pos = p + 1;
            if (p != PKT - 2)
                run_sum += w;
            if (p == 1) begin
                if (w != size_code) field_err[FLAG_SIZE] = 1'b1;
            end else if (p == 2) begin
                if (w != date_code) field_err[FLAG_DATE] = 1'b1;
            end else if (p == 3) begin
                held_kind = w;
                kind_ok   = 1'b0;
                foreach (kind_codes[k])
                    if (w == kind_codes[k]) kind_ok = 1'b1;
                if (!kind_ok) field_err[FLAG_TYPE] = 1'b1;
            end else if (p == 4) begin
                held_event = w;
            end else if (p == 5) begin
                held_origin = w;
            end else if (p <= PKT - 4) begin
                got             = 1'b1;
                r.payload_index = 8'(p - 6);
                r.payload_word  = w;
            end else if (p == PKT - 3) begin
                held_unit = w;
            end else if (p == PKT - 2) begin
                held_sum = w;
            end else begin
                got           = 1'b1;
                r.is_status   = 1'b1;
                r.evt_num     = held_event;
                r.packet_kind = held_kind;
                r.origin_word = held_origin;
                r.unit_id     = held_unit;
                r.error_flags = {3'b000, field_err};
                r.error_flags[FLAG_CHECKSUM]  = (held_sum != run_sum);
                r.error_flags[FLAG_FOOTER]    = (w != ftr_code);
                r.error_flags[FLAG_MISPLACED] = misplaced;
                in_hunt = 1'b1;
                pos     = 0;
            end
        end
    endtask

    function automatic logic [31:0] any_word();
        logic [31:0] w;
        case ($urandom_range(19))
            0:       w = '0;
            1:       w = '1;
            default: w = $urandom;
        endcase
        return (w == hdr_code) ? ~w : w;
    endfunction

    // typed_idx >= 0 gives the payload index the word must come back with
    task automatic send_word(input logic [31:0] w, input int typed_idx);
        bit      got;
        result_t r;
        while (!calm && $urandom_range(99) < 6) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= w;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        frame_word(w, got, r);
        if (typed_idx >= 0) begin
            r = '0;
            r.payload_index = 8'(typed_idx);
            r.payload_word  = w;
            deframed_q.push_back(r);
        end else if (got) begin
            deframed_q.push_back(r);
        end
    endtask

    task automatic write_reg(input cfg_reg_t idx, input logic [63:0] v);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= v;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        case (idx)
            REG_HEADER:      hdr_code  = v[31:0];
            REG_FOOTER:      ftr_code  = v[31:0];
            REG_SIZE:        size_code = v[31:0];
            REG_DATE:        date_code = v[31:0];
            REG_TYPE_PAIR_A: begin kind_codes[0] = v[31:0]; kind_codes[1] = v[63:32]; end
            REG_TYPE_PAIR_B: begin kind_codes[2] = v[31:0]; kind_codes[3] = v[63:32]; end
            REG_TYPE_FIFTH:  kind_codes[4] = v[31:0];
            default: ;
        endcase
    endtask

    // drains the block, then rewrites every register
    task automatic load_setting(input logic [63:0] h, f, sz, dt, pa, pb, t5);
        s_tvalid <= 1'b0;
        while (deframed_q.size() != 0) @(posedge aclk);
        repeat (6) @(posedge aclk);
        write_reg(REG_HEADER, h);
        write_reg(REG_FOOTER, f);
        write_reg(REG_SIZE, sz);
        write_reg(REG_DATE, dt);
        write_reg(REG_TYPE_PAIR_A, pa);
        write_reg(REG_TYPE_PAIR_B, pb);
        write_reg(REG_TYPE_FIFTH, t5);
        cfg_valid <= 1'b0;
        n_settings++;
    endtask

    task automatic send_packet();
        logic [31:0] pkt [PKT];
        logic [31:0] total;
        int          cut, i;
        case ($urandom_range(15))
            0:       cut = PKT - 1;
            1:       cut = $urandom_range(PKT - 2, 1);
            default: cut = PKT;
        endcase
        // cut short just before the footer and just before the checksum
        if (n_packets == 1) cut = PKT - 1;
        if (n_packets == 4) cut = PKT - 2;
        pkt[0] = hdr_code;
        for (i = 1; i < PKT; i++) pkt[i] = any_word();
        if ($urandom_range(99) < 88) pkt[1] = size_code;
        if ($urandom_range(99) < 88) pkt[2] = date_code;
        if ($urandom_range(99) < 88) pkt[3] = kind_codes[$urandom_range(TYPE_CODES - 1)];
        if ($urandom_range(99) < 88) pkt[PKT-1] = ftr_code;
        total = '0;
        for (i = 0; i < PKT; i++)
            if (i != PKT - 2) total += pkt[i];
        if ($urandom_range(99) < 88) pkt[PKT-2] = total;
        for (i = 0; i < cut; i++) send_word(pkt[i], -1);
        n_words += cut;
        n_packets++;
    endtask

    // result side
    initial begin : drain
        result_t got, want;
        forever begin
            @(posedge aclk);
            if (aresetn && m_tvalid && m_tready) begin
                got.is_status     = m_tuser;
                got.payload_index = m_tdata[7:0];
                got.payload_word  = m_tdata[39:8];
                got.evt_num       = m_tdata[71:40];
                got.packet_kind   = m_tdata[103:72];
                got.origin_word   = m_tdata[135:104];
                got.unit_id       = m_tdata[167:136];
                got.error_flags   = m_tdata[173:168];
                if (deframed_q.size() == 0) begin
                    note_mismatch("result with nothing pending", got.payload_word, '0);
                end else begin
                    want = deframed_q.pop_front();
                    if (got.is_status != want.is_status)
                        note_mismatch("is_status", 32'(got.is_status), 32'(want.is_status));
                    if (got.payload_index != want.payload_index)
                        note_mismatch("payload_index", 32'(got.payload_index),
                                      32'(want.payload_index));
                    if (got.payload_word != want.payload_word)
                        note_mismatch("payload_word", got.payload_word, want.payload_word);
                    if (got.evt_num != want.evt_num)
                        note_mismatch("evt_num", got.evt_num, want.evt_num);
                    if (got.packet_kind != want.packet_kind)
                        note_mismatch("packet_kind", got.packet_kind, want.packet_kind);
                    if (got.origin_word != want.origin_word)
                        note_mismatch("origin_word", got.origin_word, want.origin_word);
                    if (got.unit_id != want.unit_id)
                        note_mismatch("unit_id", got.unit_id, want.unit_id);
                    if (got.error_flags != want.error_flags)
                        note_mismatch("error_flags", 32'(got.error_flags),
                                      32'(want.error_flags));
                    if (want.is_status) n_status++;
                    else                n_payload++;
                end
            end
            // one long hold-off so the block backs up into s_tready
            if (!held_off && n_payload >= 200) begin
                held_off = 1'b1;
                m_tready <= 1'b0;
                repeat (300) @(posedge aclk);
            end
            m_tready <= (calm || $urandom_range(99) >= 6);
        end
    end

    initial begin : stimulus
        int i, ph, start;
        probe_word = '{32'hFFFF_FFFF, 32'h0000_0000, HDR_A, SIZE_A, DATE_A, KIND5_A,
                       32'hFFFF_FFFF, 32'h0000_0000, 32'h0000_0000, 32'hFFFF_FFFF,
                       32'h8000_0000, 32'h0000_0001, HDR_A, 32'h0000_0000,
                       32'hFFFF_FFFF, 32'h0000_0666, 32'h0000_0000, 32'hFFFF_FFFF,
                       32'h5555_5555, 32'hAAAA_AAAA, HDR_A, SIZE_A, DATE_A,
                       KINDS_A[31:0]};
        probe_index = '{-1, -1, -1, -1, -1, -1, -1, -1, 0, 1, 2, 3,
                        -1, -1, -1, -1, -1, -1, 0, 1, -1, -1, -1, -1};

        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        load_setting(HDR_A, FTR_A, SIZE_A, DATE_A, KINDS_A, KINDS_B, KIND5_A);
        // words dropped while hunting, a packet start, a mid-packet header with bad fields
        for (i = 0; i < PROBES; i++) send_word(probe_word[i], probe_index[i]);
        n_words += PROBES;

        for (ph = 0; ph < 5; ph++) begin
            case (ph)
                0: load_setting(HDR_A, FTR_A, SIZE_A, DATE_A, KINDS_A, KINDS_B, KIND5_A);
                1: load_setting(64'h0, '1, '1, '1, 64'hFFFF_FFFF_FFFF_FFFE,
                                64'h0000_0001_7FFF_FFFF, 64'h8000_0000);
                2: load_setting(64'hFFFF_FFFF, 64'h0, 64'h0, 64'h0, 64'h0,
                                64'h8000_0000_0000_0001, 64'hFFFF_FFFE);
                default:
                    load_setting({$urandom, $urandom}, {$urandom, $urandom},
                                 {$urandom, $urandom}, {$urandom, $urandom},
                                 {$urandom, $urandom}, {$urandom, $urandom},
                                 {$urandom, $urandom});
            endcase
            calm  = (ph == 2);
            start = n_words;
            // at least three packets in the fixed settings, at least two in each random one
            while (n_words - start < ((ph < 3) ? 320 : 200)) begin
                if ($urandom_range(99) < 30) begin
                    repeat ($urandom_range(4, 1)) begin
                        send_word(any_word(), -1);
                        n_words++;
                    end
                end
                send_packet();
            end
        end

        s_tvalid <= 1'b0;
        while (deframed_q.size() != 0) @(posedge aclk);
        repeat (10) @(posedge aclk);
        $display("tb: %0d stream words, %0d packets, %0d register settings",
                 n_words, n_packets, n_settings);
        $display("tb: %0d payload words and %0d status reports checked",
                 n_payload, n_status);
        if (mismatches == 0)
            $display("tb: done, clean");
        else
            $display("tb: done, errors");
        $finish;
    end

    initial begin : watchdog
        #3_000_000;
        $display("tb: done, errors");
        $finish;
    end

endmodule

// File: filelist.f
rtl/core/wpdc_pkg.sv
rtl/core/wpdc_cfg.sv
rtl/core/wpdc_frame.sv
rtl/core/wpdc_out.sv
rtl/core/word_packet_deframer_checker.sv
sim/tb.sv
